@@ rtl/dapm_pkg.sv @@
// ----------------------------------------------------------------------------
// dapm_pkg
// shared widths, constants and types of the dual-axis pid motor mixer
// ----------------------------------------------------------------------------
package dapm_pkg;

    localparam int ANGLE_W    = 16;
    localparam int ERR_W      = 15;               // halved error
    localparam int DIFF_W     = ERR_W + 1;        // error minus previous
    localparam int SUM_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int THR_W      = 12;
    localparam int TRIM_W     = 12;
    localparam int CMP_W      = 12;
    localparam int MOTORS     = 4;

    localparam int P_W        = GAIN_W + ERR_W;
    localparam int I_W        = GAIN_W + SUM_W;
    localparam int D_W        = GAIN_W + DIFF_W;
    localparam int CORR_W     = I_W + 1;
    localparam int MOTOR_W    = CORR_W + 2;

    localparam int SPEED_W    = 12;
    localparam int SCALED_W   = 22;               // speed * 1619 + 642 fits here
    localparam int RECIP_W    = 23;
    localparam int RECIP_SHIFT = 32;

    localparam logic [SPEED_W-1:0]  SPEED_MIN = 12'd700;
    localparam logic [SPEED_W-1:0]  SPEED_MAX = 12'd2400;
    localparam logic [10:0]         SCALE_MUL = 11'd1619;
    localparam logic [9:0]          SCALE_ADD = 10'd642;
    // ceil(2^32 / 1000), exact floor division for all scaled values in range
    localparam logic [RECIP_W-1:0]  RECIP_1000 = 23'd4294968;

    localparam logic [THR_W-1:0]    THROTTLE_RESET = 12'd750;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_BASE_THROTTLE,
        REG_TRIM_MOTOR1,
        REG_TRIM_MOTOR2,
        REG_TRIM_MOTOR3,
        REG_TRIM_MOTOR4
    } cfg_reg_t;

    // load enables of the six pipeline registers
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

    typedef logic [MOTORS-1:0][TRIM_W-1:0]  trim_vec_t;
    typedef logic [MOTORS-1:0][SPEED_W-1:0] speed_vec_t;
    typedef logic [MOTORS-1:0][CMP_W-1:0]   cmp_vec_t;
    typedef logic [MOTORS-1:0]              motor_flags_t;

endpackage

@@ rtl/dapm_in_if.sv @@
// ----------------------------------------------------------------------------
// dapm_in_if
// error sample channel: valid, ready and the roll and pitch errors
// ----------------------------------------------------------------------------
interface dapm_in_if;
    import dapm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;

    modport source (output valid, output roll_angle, output pitch_angle, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

@@ rtl/dapm_out_if.sv @@
// ----------------------------------------------------------------------------
// dapm_out_if
// motor result channel: four compare values and the bound flags
// ----------------------------------------------------------------------------
interface dapm_out_if;
    import dapm_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMP_W-1:0]  compare1;
    logic [CMP_W-1:0]  compare2;
    logic [CMP_W-1:0]  compare3;
    logic [CMP_W-1:0]  compare4;
    logic [MOTORS-1:0] low_bound_hits;
    logic [MOTORS-1:0] high_bound_hits;

    modport source (
        output valid, output compare1, output compare2, output compare3,
        output compare4, output low_bound_hits, output high_bound_hits,
        input  ready
    );
    modport sink (
        input  valid, input compare1, input compare2, input compare3,
        input  compare4, input low_bound_hits, input high_bound_hits,
        output ready
    );
endinterface

@@ rtl/dual_axis_pid_quad_motor_mixer.sv @@
// ----------------------------------------------------------------------------
// dual_axis_pid_quad_motor_mixer
// roll and pitch pid loops feeding a plus-layout four-motor mixer
// ----------------------------------------------------------------------------
// usage: each transaction on sample carries one roll and one pitch error.
// every accepted transaction yields exactly one transaction on result with
// four pwm compare values and the per-motor low and high bound flags.
// gains, base throttle and motor trims are written through the cfg port
// while the block is idle; index follows the register list of cfg_reg_t.
// result valid rises once the sample has passed the pipeline registers.
// throughput is one transaction per cycle while result is not stalled,
// set by a six-register pipeline: error and sum update, the pid multiplies,
// the correction sum, mixing and saturation, the 1619 scale, and the
// reciprocal multiply that divides by 1000. the integral sums and previous
// errors update at accept, so back-to-back samples see each other's state
// with no extra wait.
// when result stalls, each stage holds and bubbles are squeezed out, so up to
// six transactions wait in flight before sample.ready drops.
// reset empties the pipeline, clears sums and previous errors, zeroes the
// gains and trims, and sets the base throttle to 750.
// ----------------------------------------------------------------------------
module dual_axis_pid_quad_motor_mixer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [dapm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dapm_pkg::CFG_DATA_W-1:0]     cfg_data,
    dapm_in_if.sink                             sample,
    dapm_out_if.source                          result
);
    import dapm_pkg::*;

    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;
    logic [THR_W-1:0]         base_throttle_reg;
    trim_vec_t                trim_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    stage_en_t                en;
    logic                     accept;

    logic signed [CORR_W-1:0] corr_roll;
    logic signed [CORR_W-1:0] corr_pitch;
    speed_vec_t               speed;
    motor_flags_t             low_mix;
    motor_flags_t             high_mix;
    cmp_vec_t                 compare;
    motor_flags_t             low_out;
    motor_flags_t             high_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg        <= '0;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
            base_throttle_reg <= THROTTLE_RESET;
            trim_reg          <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:        gain_p_reg        <= cfg_data;
                REG_GAIN_I:        gain_i_reg        <= cfg_data;
                REG_GAIN_D:        gain_d_reg        <= cfg_data;
                REG_BASE_THROTTLE: base_throttle_reg <= cfg_data[THR_W-1:0];
                REG_TRIM_MOTOR1:   trim_reg[0]       <= cfg_data[TRIM_W-1:0];
                REG_TRIM_MOTOR2:   trim_reg[1]       <= cfg_data[TRIM_W-1:0];
                REG_TRIM_MOTOR3:   trim_reg[2]       <= cfg_data[TRIM_W-1:0];
                REG_TRIM_MOTOR4:   trim_reg[3]       <= cfg_data[TRIM_W-1:0];
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en.s6 = !v6_reg || result.ready;
        en.s5 = !v5_reg || en.s6;
        en.s4 = !v4_reg || en.s5;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign sample.ready = en.s1;
    assign accept       = sample.valid && en.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en.s1) v1_reg <= sample.valid;
            if (en.s2) v2_reg <= v1_reg;
            if (en.s3) v3_reg <= v2_reg;
            if (en.s4) v4_reg <= v3_reg;
            if (en.s5) v5_reg <= v4_reg;
            if (en.s6) v6_reg <= v5_reg;
        end
    end

    dapm_axis u_roll (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .accept (accept),
        .angle  (sample.roll_angle),
        .gain_p (gain_p_reg),
        .gain_i (gain_i_reg),
        .gain_d (gain_d_reg),
        .corr   (corr_roll)
    );

    dapm_axis u_pitch (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .accept (accept),
        .angle  (sample.pitch_angle),
        .gain_p (gain_p_reg),
        .gain_i (gain_i_reg),
        .gain_d (gain_d_reg),
        .corr   (corr_pitch)
    );

    dapm_mixer u_mixer (
        .clk           (clk),
        .en            (en),
        .corr_roll     (corr_roll),
        .corr_pitch    (corr_pitch),
        .base_throttle (base_throttle_reg),
        .trims         (trim_reg),
        .speed         (speed),
        .low_hits      (low_mix),
        .high_hits     (high_mix)
    );

    dapm_scale u_scale (
        .clk      (clk),
        .en       (en),
        .speed    (speed),
        .low_in   (low_mix),
        .high_in  (high_mix),
        .compare  (compare),
        .low_out  (low_out),
        .high_out (high_out)
    );

    assign result.valid           = v6_reg;
    assign result.compare1        = compare[0];
    assign result.compare2        = compare[1];
    assign result.compare3        = compare[2];
    assign result.compare4        = compare[3];
    assign result.low_bound_hits  = low_out;
    assign result.high_bound_hits = high_out;

endmodule

@@ rtl/dapm_axis.sv @@
// ----------------------------------------------------------------------------
// dapm_axis
// one pid axis: halving, running sum, difference, products and correction
// ----------------------------------------------------------------------------
module dapm_axis (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dapm_pkg::stage_en_t                en,
    input  logic                               accept,
    input  logic signed [dapm_pkg::ANGLE_W-1:0] angle,
    input  logic signed [dapm_pkg::GAIN_W-1:0]  gain_p,
    input  logic signed [dapm_pkg::GAIN_W-1:0]  gain_i,
    input  logic signed [dapm_pkg::GAIN_W-1:0]  gain_d,
    output logic signed [dapm_pkg::CORR_W-1:0]  corr
);
    import dapm_pkg::*;

    logic signed [ANGLE_W-1:0] biased;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [DIFF_W-1:0]  diff;

    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [ERR_W-1:0]   prev_reg;

    logic signed [ERR_W-1:0]   err1_reg;
    logic signed [SUM_W-1:0]   sum1_reg;
    logic signed [DIFF_W-1:0]  diff1_reg;

    logic signed [P_W-1:0]     p2_reg;
    logic signed [I_W-1:0]     i2_reg;
    logic signed [D_W-1:0]     d2_reg;

    logic signed [CORR_W-1:0]  corr3_reg;

    // add one to negatives before the shift so the halving truncates toward zero
    assign biased   = angle + $signed({{(ANGLE_W-1){1'b0}}, angle[ANGLE_W-1]});
    assign err      = biased[ANGLE_W-1:1];
    assign sum_next = sum_reg + {{(SUM_W-ERR_W){err[ERR_W-1]}}, err};
    assign diff     = {err[ERR_W-1], err} - {prev_reg[ERR_W-1], prev_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else if (accept)
        begin
            sum_reg  <= sum_next;
            prev_reg <= err;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            err1_reg  <= err;
            sum1_reg  <= sum_next;
            diff1_reg <= diff;
        end
        if (en.s2)
        begin
            p2_reg <= gain_p * err1_reg;
            i2_reg <= gain_i * sum1_reg;
            d2_reg <= gain_d * diff1_reg;
        end
        if (en.s3)
        begin
            corr3_reg <= CORR_W'(p2_reg) + CORR_W'(i2_reg) + CORR_W'(d2_reg);
        end
    end

    assign corr = corr3_reg;

endmodule

@@ rtl/dapm_mixer.sv @@
// ----------------------------------------------------------------------------
// dapm_mixer
// plus-layout motor mixing with saturation to the speed bounds
// ----------------------------------------------------------------------------
module dapm_mixer (
    input  logic                               clk,
    input  dapm_pkg::stage_en_t                en,
    input  logic signed [dapm_pkg::CORR_W-1:0]  corr_roll,
    input  logic signed [dapm_pkg::CORR_W-1:0]  corr_pitch,
    input  logic [dapm_pkg::THR_W-1:0]          base_throttle,
    input  dapm_pkg::trim_vec_t                 trims,
    output dapm_pkg::speed_vec_t                speed,
    output dapm_pkg::motor_flags_t              low_hits,
    output dapm_pkg::motor_flags_t              high_hits
);
    import dapm_pkg::*;

    localparam logic signed [MOTOR_W-1:0] MIN_W = MOTOR_W'(SPEED_MIN);
    localparam logic signed [MOTOR_W-1:0] MAX_W = MOTOR_W'(SPEED_MAX);

    logic signed [MOTOR_W-1:0] base_w;
    logic signed [MOTOR_W-1:0] cr;
    logic signed [MOTOR_W-1:0] cp;
    logic signed [MOTOR_W-1:0] trim_w [MOTORS];
    logic signed [MOTOR_W-1:0] motor  [MOTORS];
    speed_vec_t                speed_next;
    motor_flags_t              low_next;
    motor_flags_t              high_next;

    speed_vec_t                speed_reg;
    motor_flags_t              low_reg;
    motor_flags_t              high_reg;

    always_comb
    begin
        base_w = $signed({{(MOTOR_W-THR_W){1'b0}}, base_throttle});
        cr     = MOTOR_W'(corr_roll);
        cp     = MOTOR_W'(corr_pitch);
        for (int i = 0; i < MOTORS; i++)
        begin
            trim_w[i] = MOTOR_W'($signed(trims[i]));
        end
        // motors 1 and 3 on pitch, 2 and 4 on roll
        motor[0] = base_w - cp + trim_w[0];
        motor[1] = base_w - cr + trim_w[1];
        motor[2] = base_w + cp + trim_w[2];
        motor[3] = base_w + cr + trim_w[3];
        for (int i = 0; i < MOTORS; i++)
        begin
            low_next[i]  = (motor[i] <= MIN_W);
            high_next[i] = (motor[i] >= MAX_W);
            if (low_next[i])
                speed_next[i] = SPEED_MIN;
            else if (high_next[i])
                speed_next[i] = SPEED_MAX;
            else
                speed_next[i] = motor[i][SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            speed_reg <= speed_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
    end

    assign speed     = speed_reg;
    assign low_hits  = low_reg;
    assign high_hits = high_reg;

endmodule

@@ rtl/dapm_scale.sv @@
// ----------------------------------------------------------------------------
// dapm_scale
// speed to pwm compare value, floor((v * 1619 + 642) / 1000)
// ----------------------------------------------------------------------------
module dapm_scale (
    input  logic                  clk,
    input  dapm_pkg::stage_en_t   en,
    input  dapm_pkg::speed_vec_t  speed,
    input  dapm_pkg::motor_flags_t low_in,
    input  dapm_pkg::motor_flags_t high_in,
    output dapm_pkg::cmp_vec_t    compare,
    output dapm_pkg::motor_flags_t low_out,
    output dapm_pkg::motor_flags_t high_out
);
    import dapm_pkg::*;

    localparam int PROD_W = SCALED_W + RECIP_W;

    logic [SCALED_W-1:0] scaled_reg [MOTORS];
    motor_flags_t        low5_reg;
    motor_flags_t        high5_reg;

    logic [PROD_W-1:0]   prod [MOTORS];
    cmp_vec_t            cmp_reg;
    motor_flags_t        low6_reg;
    motor_flags_t        high6_reg;

    // divide by 1000 as a multiply by the rounded-up reciprocal
    always_comb
    begin
        for (int i = 0; i < MOTORS; i++)
        begin
            prod[i] = PROD_W'(scaled_reg[i]) * PROD_W'(RECIP_1000);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            for (int i = 0; i < MOTORS; i++)
            begin
                scaled_reg[i] <= SCALED_W'(speed[i]) * SCALED_W'(SCALE_MUL)
                                 + SCALED_W'(SCALE_ADD);
            end
            low5_reg  <= low_in;
            high5_reg <= high_in;
        end
        if (en.s6)
        begin
            for (int i = 0; i < MOTORS; i++)
            begin
                cmp_reg[i] <= prod[i][RECIP_SHIFT +: CMP_W];
            end
            low6_reg  <= low5_reg;
            high6_reg <= high5_reg;
        end
    end

    assign compare  = cmp_reg;
    assign low_out  = low6_reg;
    assign high_out = high6_reg;

endmodule
